/* design/mlm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlm_pkg: shared types and codes for the mutex lock manager
// Action and status codes, default sizes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package mlm_pkg;

    localparam int NumLocksDef   = 16;
    localparam int NumThreadsDef = 64;
    localparam int ActW          = 2;
    localparam int LockW         = 4;
    localparam int IdW           = 6;
    localparam int StatusW       = 3;

    localparam logic [ActW-1:0] ACT_LOCK   = 2'd0;
    localparam logic [ActW-1:0] ACT_TRY    = 2'd1;
    localparam logic [ActW-1:0] ACT_UNLOCK = 2'd2;

    localparam logic [StatusW-1:0] ST_GRANTED   = 3'd0;
    localparam logic [StatusW-1:0] ST_QUEUED    = 3'd1;
    localparam logic [StatusW-1:0] ST_BUSY      = 3'd2;
    localparam logic [StatusW-1:0] ST_RELEASED  = 3'd3;
    localparam logic [StatusW-1:0] ST_HANDOFF   = 3'd4;
    localparam logic [StatusW-1:0] ST_BADUNLOCK = 3'd5;
    localparam logic [StatusW-1:0] ST_REJECTED  = 3'd6;

    // Request word as it travels from front to back
    typedef struct packed {
        logic [ActW-1:0]  action;
        logic [LockW-1:0] lock_index;
        logic [IdW-1:0]   requester_id;
    } req_t;

endpackage

/* design/mlm_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlm_front: request intake and filter
// Drop malformed words and push the rest into a two-entry queue.
// ----------------------------------------------------------------------------
module mlm_front
    import mlm_pkg::*;
#(
    parameter int NUM_LOCKS   = NumLocksDef,
    parameter int NUM_THREADS = NumThreadsDef
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ActW-1:0]  action,
    input  logic [LockW-1:0] lock_index,
    input  logic [IdW-1:0]   requester_id,
    output logic             q_valid,
    input  logic             q_ready,
    output req_t             q_word
);

    req_t       buf_reg [2];
    logic       rd_ptr_reg, rd_ptr_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       good;
    logic       push, pop;

    assign good = (action <= ACT_UNLOCK)
               && ({1'b0, lock_index} < (LockW+1)'(NUM_LOCKS))
               && ({4'd0, requester_id} < (IdW+4)'(NUM_THREADS));
    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_word   = buf_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready && good;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= '{action: action, lock_index: lock_index,
                                     requester_id: requester_id};
        end
    end

endmodule

/* design/mlm_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlm_back: lock table engine
// Read the lock and thread state, decide, write back and present the result.
// ----------------------------------------------------------------------------
module mlm_back
    import mlm_pkg::*;
#(
    parameter int NUM_LOCKS   = NumLocksDef,
    parameter int NUM_THREADS = NumThreadsDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  req_t               q_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [StatusW-1:0] status,
    output logic               woken_valid,
    output logic [IdW-1:0]     woken_id,
    output logic               contended
);

    localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int TW = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;

    typedef enum logic [0:0] {S_IDLE, S_EXEC} state_t;

    state_t state_reg;

    // Per-lock state in flops (at most 16 entries, valid-style reset)
    logic [IdW-1:0] owner_reg   [NUM_LOCKS];
    logic [IdW-1:0] head_reg    [NUM_LOCKS];
    logic [IdW-1:0] tail_reg    [NUM_LOCKS];
    logic [NUM_LOCKS-1:0]   held_reg, cont_reg, nonempty_reg;
    logic [NUM_THREADS-1:0] waiting_reg;
    // Successor links: memory, undefined until written
    logic [IdW-1:0] wait_next_mem [NUM_THREADS];
    logic [IdW-1:0] next_rd_reg;

    req_t            req_reg;
    logic [LW-1:0]   li;
    logic [TW-1:0]   tid;
    logic [IdW-1:0]  head_cur;
    logic [TW-1:0]   head_idx;

    logic [StatusW-1:0] st;
    logic               do_grant, do_queue, do_release, do_handoff;

    assign li       = req_reg.lock_index[LW-1:0];
    assign tid      = req_reg.requester_id[TW-1:0];
    assign head_cur = head_reg[li];
    assign head_idx = head_cur[TW-1:0];
    // Take the next word while idle, once the result register is empty or being drained
    assign q_ready  = (state_reg == S_IDLE) && (!out_valid || out_ready);

    always_comb
    begin
        do_grant   = 1'b0;
        do_queue   = 1'b0;
        do_release = 1'b0;
        do_handoff = 1'b0;
        if (waiting_reg[tid])
        begin
            st = ST_REJECTED;
        end
        else if (req_reg.action != ACT_UNLOCK)
        begin
            if (!held_reg[li])
            begin
                st = ST_GRANTED;
                do_grant = 1'b1;
            end
            else if (req_reg.action == ACT_TRY)
            begin
                st = ST_BUSY;
            end
            else
            begin
                st = ST_QUEUED;
                do_queue = 1'b1;
            end
        end
        else if (!held_reg[li] || owner_reg[li] != req_reg.requester_id)
        begin
            st = ST_BADUNLOCK;
        end
        else if (!nonempty_reg[li])
        begin
            st = ST_RELEASED;
            do_release = 1'b1;
        end
        else
        begin
            st = ST_HANDOFF;
            do_handoff = 1'b1;
        end
    end

    // Read the head's successor when the word is accepted
    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            next_rd_reg <= wait_next_mem[head_reg[q_word.lock_index[LW-1:0]][TW-1:0]];
        end
        if (state_reg == S_EXEC && do_queue && nonempty_reg[li])
        begin
            wait_next_mem[tail_reg[li][TW-1:0]] <= req_reg.requester_id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            req_reg <= q_word;
        end
        if (state_reg == S_EXEC)
        begin
            if (do_grant)
            begin
                owner_reg[li] <= req_reg.requester_id;
            end
            if (do_queue)
            begin
                tail_reg[li] <= req_reg.requester_id;
                if (!nonempty_reg[li])
                begin
                    head_reg[li] <= req_reg.requester_id;
                end
            end
            if (do_release)
            begin
                owner_reg[li] <= '0;
            end
            if (do_handoff)
            begin
                owner_reg[li] <= head_cur;
                if (head_cur != tail_reg[li])
                begin
                    head_reg[li] <= next_rd_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            held_reg     <= '0;
            cont_reg     <= '0;
            nonempty_reg <= '0;
            waiting_reg  <= '0;
            out_valid    <= 1'b0;
            status       <= ST_GRANTED;
            woken_valid  <= 1'b0;
            woken_id     <= '0;
            contended    <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && q_ready)
                    begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg   <= S_IDLE;
                    out_valid   <= 1'b1;
                    status      <= st;
                    woken_valid <= do_handoff;
                    woken_id    <= do_handoff ? head_cur : '0;
                    contended   <= do_queue || do_handoff
                                || (cont_reg[li] && !do_grant && !do_release);
                    if (do_grant || do_release)
                    begin
                        cont_reg[li] <= 1'b0;
                        held_reg[li] <= do_grant;
                    end
                    if (do_queue)
                    begin
                        cont_reg[li]     <= 1'b1;
                        nonempty_reg[li] <= 1'b1;
                        waiting_reg[tid] <= 1'b1;
                    end
                    if (do_handoff)
                    begin
                        cont_reg[li] <= 1'b1;
                        waiting_reg[head_idx] <= 1'b0;
                        if (head_cur == tail_reg[li])
                        begin
                            nonempty_reg[li] <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/mutex_lock_manager_fifo_handoff.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutex_lock_manager_fifo_handoff: mutex bank with FIFO waiter handoff
// Path: front queue, then request register, then decide, write back the
// lock tables and register the result. A new request is taken only once the
// last is written back; a result that is not taken holds the engine until it is.
// Reset: all mutexes free, all waiter queues empty, no thread waiting.
// ----------------------------------------------------------------------------
module mutex_lock_manager_fifo_handoff
    import mlm_pkg::*;
#(
    parameter int NUM_LOCKS   = NumLocksDef,
    parameter int NUM_THREADS = NumThreadsDef
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ActW-1:0]    action,
    input  logic [LockW-1:0]   lock_index,
    input  logic [IdW-1:0]     requester_id,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [StatusW-1:0] status,
    output logic               woken_valid,
    output logic [IdW-1:0]     woken_id,
    output logic               contended
);

    logic q_valid, q_ready;
    req_t q_word;

    mlm_front #(.NUM_LOCKS(NUM_LOCKS), .NUM_THREADS(NUM_THREADS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .lock_index(lock_index), .requester_id(requester_id),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
    );

    mlm_back #(.NUM_LOCKS(NUM_LOCKS), .NUM_THREADS(NUM_THREADS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .woken_valid(woken_valid), .woken_id(woken_id),
        .contended(contended)
    );

endmodule
